/* rtl/core/sha1_pkg.sv */
// ============================================================================
// SHA-1 engine package
// Shared constants, command/status types and round functions of the engine.
// ============================================================================
package sha1_pkg;

    // Channel widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned NUM_WORDS   = 5;
    localparam int unsigned WIN_WORDS   = 16;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
    localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
    localparam logic [POS_W-1:0]   POS_LEN    = 6'd56;

    // Byte source for the message window
    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_MARK = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t IV [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic               push;
        logic [1:0]         push_sel;
        logic               len_capture;
        logic               load_work;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               add;
        logic               out_load;
        logic [IDX_W-1:0]   out_idx;
        logic               restart;
    } sha1_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pos_last;
        logic pos_len;
    } sha1_status_t;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] r);
        if (r < 7'd20)
            round_k = K0;
        else if (r < 7'd40)
            round_k = K1;
        else if (r < 7'd60)
            round_k = K2;
        else
            round_k = K3;
    endfunction

    function automatic word_t round_f(input logic [ROUND_W-1:0] r, input word_t b,
                                      input word_t c, input word_t d);
        if (r < 7'd20)
            round_f = (b & c) | (~b & d);
        else if (r >= 7'd40 && r < 7'd60)
            round_f = (b & c) | (b & d) | (c & d);
        else
            round_f = b ^ c ^ d;
    endfunction

endpackage

/* rtl/core/sha1_dp.sv */
// ============================================================================
// SHA-1 datapath
// Message window, byte counter, length register, round unit, chaining value
// and the digest output register.
// ============================================================================
module sha1_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sha1_pkg::sha1_cmd_t                 cmd,
    input  logic [7:0]                          in_byte,
    output sha1_pkg::sha1_status_t              status,
    output logic [sha1_pkg::WORD_W-1:0]         out_word,
    output logic [sha1_pkg::IDX_W-1:0]          out_idx,
    output logic                                out_last
);
    import sha1_pkg::*;

    word_t               win_reg [WIN_WORDS];
    logic [POS_W-1:0]    pos_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [LEN_W-1:0]    len_reg;
    word_t               chain_reg [NUM_WORDS];
    word_t               a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t               out_word_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_last_reg;

    logic [7:0]          push_byte;
    word_t               sched_next;
    word_t               t_next;

    // Pick the byte that enters the window
    always_comb
    begin
        case (cmd.push_sel)
            SEL_DATA: push_byte = in_byte;
            SEL_MARK: push_byte = PAD_MARK;
            SEL_ZERO: push_byte = 8'h00;
            SEL_LEN:  push_byte = len_reg[LEN_W-1 -: 8];
            default:  push_byte = 8'h00;
        endcase
    end

    // Schedule expansion and round sum
    assign sched_next = rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);
    assign t_next     = rotl(a_reg, 5) + round_f(cmd.round, b_reg, c_reg, d_reg)
                      + e_reg + round_k(cmd.round) + win_reg[0];

    assign status.pos_last = (pos_reg == POS_LAST);
    assign status.pos_len  = (pos_reg == POS_LEN);

    // Shift bytes in, or advance the schedule window by one word per round
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            for (int i = 0; i < WIN_WORDS - 1; i++)
                win_reg[i] <= {win_reg[i][WORD_W-9:0], win_reg[i+1][WORD_W-1 -: 8]};
            win_reg[WIN_WORDS-1] <= {win_reg[WIN_WORDS-1][WORD_W-9:0], push_byte};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < WIN_WORDS - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[WIN_WORDS-1] <= sched_next;
        end
    end

    // Block position and message byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.push)
                pos_reg <= pos_reg + 1'b1;
            if (cmd.restart)
                count_reg <= '0;
            else if (cmd.push && cmd.push_sel == SEL_DATA)
                count_reg <= count_reg + 1'b1;
        end
    end

    // Latch the bit length, then hand it out a byte at a time
    always_ff @(posedge clk)
    begin
        if (cmd.len_capture)
            len_reg <= {count_reg, 3'b000};
        else if (cmd.push && cmd.push_sel == SEL_LEN)
            len_reg <= {len_reg[LEN_W-9:0], 8'h00};
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
                chain_reg[i] <= IV[i];
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
                chain_reg[i] <= IV[i];
        end
        else if (cmd.add)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    // Digest output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg <= chain_reg[cmd.out_idx];
            out_idx_reg  <= cmd.out_idx;
            out_last_reg <= (cmd.out_idx == LAST_IDX);
        end
    end

    assign out_word = out_word_reg;
    assign out_idx  = out_idx_reg;
    assign out_last = out_last_reg;

endmodule

/* rtl/core/sha1_ctrl.sv */
// ============================================================================
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds, the chaining add and the
// five digest beats.
// ============================================================================
module sha1_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_byte_valid,
    input  logic                    in_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  sha1_pkg::sha1_status_t  status,
    output sha1_pkg::sha1_cmd_t     cmd
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;
    localparam logic [2:0] S_LEN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // What follows a compression
    localparam logic [1:0] CTX_DATA  = 2'd0;
    localparam logic [1:0] CTX_PAD   = 2'd1;
    localparam logic [1:0] CTX_FINAL = 2'd2;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         ctx_reg, ctx_next;
    logic               fin_reg, fin_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   word_reg, word_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        fin_next       = fin_reg;
        round_next     = round_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.round      = round_reg;
        cmd.out_idx    = word_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_byte_valid)
                    begin
                        cmd.push     = 1'b1;
                        cmd.push_sel = SEL_DATA;
                        if (status.pos_last)
                        begin
                            cmd.load_work = 1'b1;
                            ctx_next      = CTX_DATA;
                            fin_next      = in_end;
                            state_next    = S_ROUND;
                        end
                        else if (in_end)
                            state_next = S_MARK;
                    end
                    else if (in_end)
                        state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.push        = 1'b1;
                cmd.push_sel    = SEL_MARK;
                cmd.len_capture = 1'b1;
                if (status.pos_last)
                begin
                    cmd.load_work = 1'b1;
                    ctx_next      = CTX_PAD;
                    state_next    = S_ROUND;
                end
                else
                    state_next = S_ZERO;
            end
            S_ZERO:
            begin
                if (status.pos_len)
                    state_next = S_LEN;
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = SEL_ZERO;
                    if (status.pos_last)
                    begin
                        cmd.load_work = 1'b1;
                        ctx_next      = CTX_PAD;
                        state_next    = S_ROUND;
                    end
                end
            end
            S_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = SEL_LEN;
                if (status.pos_last)
                begin
                    cmd.load_work = 1'b1;
                    ctx_next      = CTX_FINAL;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = S_ADD;
                end
                else
                    round_next = round_reg + 1'b1;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                case (ctx_reg)
                    CTX_DATA:
                    begin
                        fin_next   = 1'b0;
                        state_next = fin_reg ? S_MARK : S_IDLE;
                    end
                    CTX_PAD:   state_next = S_ZERO;
                    CTX_FINAL:
                    begin
                        word_next  = '0;
                        state_next = S_OUT;
                    end
                    default:   state_next = S_IDLE;
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    if (word_reg == LAST_IDX)
                    begin
                        cmd.restart = 1'b1;
                        word_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                        word_next = word_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctx_reg       <= CTX_DATA;
            fin_reg       <= 1'b0;
            round_reg     <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            fin_reg       <= fin_next;
            round_reg     <= round_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Round counter stays within the 80 rounds
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (round_reg <= LAST_ROUND))
        else $error("round counter out of range");

    // Window never shifts a byte and a round together
    a_push_round: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.round_en))
        else $error("byte push during a round");

    // Digest beats only follow a final chaining add
    a_out_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> ($past(state_reg) == S_ADD || $past(state_reg) == S_OUT))
        else $error("digest output entered out of sequence");

    // Apart from reset, the chaining value returns to the IV only on the last digest beat
    a_restart_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |-> (cmd.out_load && word_reg == LAST_IDX))
        else $error("restart outside the last digest beat");

endmodule

/* rtl/core/sha1_hash_engine_top.sv */
// ============================================================================
// SHA-1 hash engine
// Byte-serial SHA-1 with a streaming input of message bytes and a streaming
// output of the five digest words.
// ============================================================================
// A message byte is taken whenever the engine is idle. The byte that
// completes a 64-byte block is followed by a compression in which the input
// is held off: 80 rounds through the single round unit, one per cycle, then
// the chaining add. The end of a message pushes the padding and length bytes
// up to the end of the block (plus a step with no byte on reaching byte 56),
// one or two further compressions, and five output beats, most significant
// digest word first. The input is taken again as soon as the last digest word
// sits in the output register; the engine then starts the next message from
// the initial hash value.
// ============================================================================
module sha1_hash_engine_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sha1_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic                                s_axis_tuser,   // [0] byte_valid
    input  logic                                s_axis_tlast,   // end_of_message
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sha1_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [31:0] digest_word,
                                                                // [34:32] word_index,
                                                                // [39:35] zero
    output logic                                m_axis_tlast    // last_word
);
    import sha1_pkg::*;

    sha1_cmd_t           cmd;
    sha1_status_t        status;
    word_t               out_word;
    logic [IDX_W-1:0]    out_idx;
    logic                out_last;

    // Controller
    sha1_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_byte_valid (s_axis_tuser),
        .in_end        (s_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Datapath
    sha1_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_byte  (s_axis_tdata),
        .status   (status),
        .out_word (out_word),
        .out_idx  (out_idx),
        .out_last (out_last)
    );

    // Pack the result beat
    assign m_axis_tdata = {{(OUT_TDATA_W - WORD_W - IDX_W){1'b0}}, out_idx, out_word};
    assign m_axis_tlast = out_last;

endmodule
